@@ hdl/swrdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Single-wire register datagram master: shared package
// Types, codes, constants and the CRC-8 byte update used by the link master.
// ----------------------------------------------------------------------------
`default_nettype none

package swrdm_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int REG_W   = 7;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 4;
    localparam int TICK_W  = 8;
    localparam int CFGI_W  = 2;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RXB   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

    // Result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Report status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_CRC_ERR  = 2'd2;
    localparam logic [STAT_W-1:0] ST_REJECTED = 2'd3;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_WRITE_ECHO = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_READ_ECHO  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_REPLY      = 2'd2;

    // Reset values of the tick limits
    localparam logic [TICK_W-1:0] WRITE_ECHO_TICKS_RST = 8'd20;
    localparam logic [TICK_W-1:0] READ_ECHO_TICKS_RST  = 8'd10;
    localparam logic [TICK_W-1:0] REPLY_TICKS_RST      = 8'd20;

    // Datagram constants
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h05;
    localparam logic [BYTE_W-1:0] WRITE_BIT = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;
    localparam logic [CNT_W-1:0]  WRITE_LEN = 4'd8;
    localparam logic [CNT_W-1:0]  READ_LEN  = 4'd4;
    localparam logic [CNT_W-1:0]  REPLY_LEN = 4'd7;
    localparam logic [CNT_W-1:0]  HDR_LEN   = 4'd3;

    // Link phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_WECHO = 4'b0010,
        PH_RECHO = 4'b0100,
        PH_REPLY = 4'b1000
    } phase_t;

    // CRC-8 update with one byte, bits taken MSB first
    function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        crc = crc_in;
        b   = data;
        for (int j = 0; j < BYTE_W; j++)
        begin
            if (crc[BYTE_W-1] ^ b[BYTE_W-1])
                crc = (crc << 1) ^ CRC_POLY;
            else
                crc = crc << 1;
            b = b << 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ hdl/swrdm_if.sv @@
// ----------------------------------------------------------------------------
// Single-wire register datagram master: channel interfaces
// Valid/ready channels for the request items and for the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface swrdm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [swrdm_pkg::CMD_W-1:0]           cmd;
    logic [swrdm_pkg::BYTE_W-1:0]          slave_addr;
    logic [swrdm_pkg::REG_W-1:0]           reg_addr;
    logic [swrdm_pkg::WORD_W-1:0]          write_value;
    logic [swrdm_pkg::BYTE_W-1:0]          rx_byte;

    modport source (output valid, cmd, slave_addr, reg_addr, write_value, rx_byte,
                    input ready);
    modport sink   (input valid, cmd, slave_addr, reg_addr, write_value, rx_byte,
                    output ready);
endinterface

interface swrdm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [swrdm_pkg::BYTE_W-1:0]          tx_byte;
    logic                                  tx_last;
    logic [swrdm_pkg::STAT_W-1:0]          status;
    logic [swrdm_pkg::WORD_W-1:0]          read_value;

    modport source (output valid, kind, tx_byte, tx_last, status, read_value,
                    input ready);
    modport sink   (input valid, kind, tx_byte, tx_last, status, read_value,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/single_wire_register_datagram_master_unit.sv @@
// ----------------------------------------------------------------------------
// Single-wire register datagram master
// Builds write and read datagrams with CRC-8, skips the line echo, collects
// and checks the read reply, and reports the outcome.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake      Payload
//  in_ch     in    valid/ready    cmd, slave_addr, reg_addr, write_value, rx_byte
//  out_ch    out   valid/ready    kind, tx_byte, tx_last, status, read_value
//  cfg       in    cfg_wr_en      cfg_index, cfg_wdata (tick limits)
//
// Each item updates the link state in the cycle it is accepted and loads its
// results into a burst register; results leave one per cycle while the sink is
// ready: a write request yields 8 results, a read request 4, a report 1, others
// none. A new item is taken while the last result of the burst is transferred.
// Output stalls hold the burst and the input. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_register_datagram_master_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    swrdm_in_if.sink                                 in_ch,
    swrdm_out_if.source                              out_ch,
    input  wire logic                                cfg_wr_en,
    input  wire logic [swrdm_pkg::CFGI_W-1:0]        cfg_index,
    input  wire logic [swrdm_pkg::TICK_W-1:0]        cfg_wdata
);

    localparam int SH_W = 7 * swrdm_pkg::BYTE_W;

    // Configuration registers
    logic [swrdm_pkg::TICK_W-1:0] wecho_lim_reg, recho_lim_reg, reply_lim_reg;

    // Link state
    swrdm_pkg::phase_t            phase_reg, phase_next;
    logic [swrdm_pkg::CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [swrdm_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [swrdm_pkg::BYTE_W-1:0] rcrc_reg, rcrc_next;
    logic [swrdm_pkg::WORD_W-1:0] rdata_reg, rdata_next;

    // Result burst
    logic [swrdm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         kind_reg, kind_next;
    logic [SH_W-1:0]              sh_reg, sh_next;
    logic [swrdm_pkg::BYTE_W-1:0] tcrc_reg;
    logic [swrdm_pkg::STAT_W-1:0] status_reg, status_next;
    logic [swrdm_pkg::WORD_W-1:0] value_reg, value_next;

    logic                         in_xfer, out_xfer;
    logic [swrdm_pkg::TICK_W-1:0] tick_inc;

    assign out_xfer    = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (cnt_reg == '0) || ((cnt_reg == 4'd1) && out_ch.ready);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign tick_inc    = (tick_reg == '1) ? tick_reg : tick_reg + 8'd1;

    // Output fields come straight from the burst registers
    assign out_ch.valid      = (cnt_reg != '0);
    assign out_ch.kind       = kind_reg;
    assign out_ch.tx_byte    = (kind_reg == swrdm_pkg::KIND_REPORT) ? '0 :
                               (cnt_reg == 4'd1) ? tcrc_reg : sh_reg[SH_W-1 -: 8];
    assign out_ch.tx_last    = (kind_reg == swrdm_pkg::KIND_TX) && (cnt_reg == 4'd1);
    assign out_ch.status     = status_reg;
    assign out_ch.read_value = value_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wecho_lim_reg <= swrdm_pkg::WRITE_ECHO_TICKS_RST;
            recho_lim_reg <= swrdm_pkg::READ_ECHO_TICKS_RST;
            reply_lim_reg <= swrdm_pkg::REPLY_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                swrdm_pkg::CFG_WRITE_ECHO: wecho_lim_reg <= cfg_wdata;
                swrdm_pkg::CFG_READ_ECHO:  recho_lim_reg <= cfg_wdata;
                swrdm_pkg::CFG_REPLY:      reply_lim_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next link state and the burst that an accepted item loads
    always_comb
    begin
        phase_next  = phase_reg;
        bcnt_next   = bcnt_reg;
        tick_next   = tick_reg;
        rcrc_next   = rcrc_reg;
        rdata_next  = rdata_reg;
        cnt_next    = '0;
        kind_next   = swrdm_pkg::KIND_REPORT;
        sh_next     = '0;
        status_next = swrdm_pkg::ST_OK;
        value_next  = '0;

        case (in_ch.cmd) inside
            swrdm_pkg::CMD_WRITE, swrdm_pkg::CMD_READ:
            begin
                if (phase_reg != swrdm_pkg::PH_IDLE)
                begin
                    cnt_next    = 4'd1;
                    status_next = swrdm_pkg::ST_REJECTED;
                end
                else
                begin
                    bcnt_next  = '0;
                    tick_next  = '0;
                    rcrc_next  = '0;
                    rdata_next = '0;
                    kind_next  = swrdm_pkg::KIND_TX;
                    if (in_ch.cmd == swrdm_pkg::CMD_WRITE)
                    begin
                        phase_next = swrdm_pkg::PH_WECHO;
                        cnt_next   = swrdm_pkg::WRITE_LEN;
                        sh_next    = {swrdm_pkg::SYNC_BYTE, in_ch.slave_addr,
                                      swrdm_pkg::WRITE_BIT | {1'b0, in_ch.reg_addr},
                                      in_ch.write_value};
                    end
                    else
                    begin
                        phase_next = swrdm_pkg::PH_RECHO;
                        cnt_next   = swrdm_pkg::READ_LEN;
                        sh_next    = {swrdm_pkg::SYNC_BYTE, in_ch.slave_addr,
                                      {1'b0, in_ch.reg_addr}, 32'd0};
                    end
                end
            end

            swrdm_pkg::CMD_RXB:
            begin
                unique case (phase_reg)
                    swrdm_pkg::PH_WECHO:
                    begin
                        bcnt_next = bcnt_reg + 4'd1;
                        if (bcnt_next >= swrdm_pkg::WRITE_LEN)
                        begin
                            phase_next = swrdm_pkg::PH_IDLE;
                            bcnt_next  = '0;
                            tick_next  = '0;
                        end
                    end
                    swrdm_pkg::PH_RECHO:
                    begin
                        bcnt_next = bcnt_reg + 4'd1;
                        if (bcnt_next >= swrdm_pkg::READ_LEN)
                        begin
                            phase_next = swrdm_pkg::PH_REPLY;
                            bcnt_next  = '0;
                            tick_next  = '0;
                        end
                    end
                    swrdm_pkg::PH_REPLY:
                    begin
                        if (bcnt_reg < swrdm_pkg::REPLY_LEN)
                        begin
                            // Header and data bytes feed the CRC; data bytes build the value.
                            rcrc_next = swrdm_pkg::crc_feed(rcrc_reg, in_ch.rx_byte);
                            if (bcnt_reg >= swrdm_pkg::HDR_LEN)
                                rdata_next = {rdata_reg[23:0], in_ch.rx_byte};
                            bcnt_next = bcnt_reg + 4'd1;
                        end
                        else
                        begin
                            cnt_next = 4'd1;
                            if (in_ch.rx_byte == rcrc_reg)
                                value_next = rdata_reg;
                            else
                                status_next = swrdm_pkg::ST_CRC_ERR;
                            phase_next = swrdm_pkg::PH_IDLE;
                            bcnt_next  = '0;
                            tick_next  = '0;
                            rcrc_next  = '0;
                            rdata_next = '0;
                        end
                    end
                    default: ;
                endcase
            end

            default:
            begin
                // One tick: count up to saturation, test after the increment.
                unique case (phase_reg)
                    swrdm_pkg::PH_WECHO:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= wecho_lim_reg)
                        begin
                            phase_next = swrdm_pkg::PH_IDLE;
                            bcnt_next  = '0;
                            tick_next  = '0;
                        end
                    end
                    swrdm_pkg::PH_RECHO:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= recho_lim_reg)
                        begin
                            phase_next = swrdm_pkg::PH_REPLY;
                            bcnt_next  = '0;
                            tick_next  = '0;
                        end
                    end
                    swrdm_pkg::PH_REPLY:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= reply_lim_reg)
                        begin
                            cnt_next    = 4'd1;
                            status_next = swrdm_pkg::ST_TIMEOUT;
                            phase_next  = swrdm_pkg::PH_IDLE;
                            bcnt_next   = '0;
                            tick_next   = '0;
                            rcrc_next   = '0;
                            rdata_next  = '0;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // Link state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= swrdm_pkg::PH_IDLE;
            bcnt_reg  <= '0;
            tick_reg  <= '0;
            rcrc_reg  <= '0;
            rdata_reg <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            bcnt_reg  <= bcnt_next;
            tick_reg  <= tick_next;
            rcrc_reg  <= rcrc_next;
            rdata_reg <= rdata_next;
        end
    end

    // Burst count: load on accept, count down on each output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (in_xfer)
            cnt_reg <= cnt_next;
        else if (out_xfer)
            cnt_reg <= cnt_reg - 4'd1;
    end

    // Burst payload; the datagram CRC accumulates as each byte leaves
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg   <= kind_next;
            sh_reg     <= sh_next;
            tcrc_reg   <= '0;
            status_reg <= status_next;
            value_reg  <= value_next;
        end
        else if (out_xfer)
        begin
            sh_reg   <= sh_reg << 8;
            tcrc_reg <= swrdm_pkg::crc_feed(tcrc_reg, sh_reg[SH_W-1 -: 8]);
        end
    end

`ifndef SYNTHESIS
    // The burst never holds more than one write datagram.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= swrdm_pkg::WRITE_LEN)
        else $error("burst count above datagram length");

    // A report is always a single result.
    a_report_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == swrdm_pkg::KIND_REPORT) |-> cnt_reg == 4'd1)
        else $error("report burst longer than one");

    // A read request taken while idle starts the echo phase with four bytes queued.
    a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_ch.cmd == swrdm_pkg::CMD_READ && phase_reg == swrdm_pkg::PH_IDLE)
        |=> (phase_reg == swrdm_pkg::PH_RECHO && cnt_reg == swrdm_pkg::READ_LEN))
        else $error("read request did not start echo phase");

    // Counters and reply data are clear whenever the link is idle.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == swrdm_pkg::PH_IDLE) |-> (bcnt_reg == '0 && tick_reg == '0
                                               && rcrc_reg == '0 && rdata_reg == '0))
        else $error("link state not cleared in idle");

    // Reply data only builds up while a reply is collected.
    a_rdata_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != swrdm_pkg::PH_REPLY) |-> rdata_reg == '0)
        else $error("reply data outside reply phase");
`endif

endmodule

`default_nettype wire

@@ tb/sv/single_wire_register_datagram_master_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Single-wire register datagram master: regression bench
// Drives request, echo, reply and tick transfers into the link master under
// random source gaps and sink stalls, and runs a cycle-free model of the link
// state. Every result transfer is compared field by field with the oldest
// predicted result. The tick limits are reloaded between phases, at reset,
// minimum, maximum, random and fixed mixed values.
// ----------------------------------------------------------------------------

module single_wire_register_datagram_master_unit_test;

    import swrdm_pkg::*;

    // One input transfer and one result transfer
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] slave_addr;
        logic [REG_W-1:0]  reg_addr;
        logic [WORD_W-1:0] write_value;
        logic [BYTE_W-1:0] rx_byte;
    } link_item_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_last;
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] read_value;
    } link_result_t;

    // Link state model and the queue of results it has predicted
    class datagram_tracker;
        logic [TICK_W-1:0] write_echo_limit;
        logic [TICK_W-1:0] read_echo_limit;
        logic [TICK_W-1:0] reply_limit;
        phase_t            link_phase;
        logic [CNT_W-1:0]  byte_cnt;
        logic [TICK_W-1:0] tick_cnt;
        logic [BYTE_W-1:0] reply_crc;
        logic [WORD_W-1:0] reply_word;
        link_result_t      due_results[$];
        int unsigned       failures;
        int unsigned       printed;
        int unsigned       accepted_items;

        function new();
            write_echo_limit = WRITE_ECHO_TICKS_RST;
            read_echo_limit  = READ_ECHO_TICKS_RST;
            reply_limit      = REPLY_TICKS_RST;
            failures         = 0;
            printed          = 0;
            accepted_items   = 0;
            enter_phase(PH_IDLE);
        endfunction

        // Every phase change starts with cleared counters and reply state.
        function void enter_phase(phase_t ph);
            link_phase = ph;
            byte_cnt   = '0;
            tick_cnt   = '0;
            reply_crc  = '0;
            reply_word = '0;
        endfunction

        // CRC-8 with polynomial x^8+x^2+x+1, zero init, data folded in MSB first.
        function logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                              input logic [BYTE_W-1:0] data);
            logic [BYTE_W-1:0] acc;
            acc = crc ^ data;
            for (int j = 0; j < BYTE_W; j++)
                acc = acc[BYTE_W-1] ? ({acc[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
                                    : {acc[BYTE_W-2:0], 1'b0};
            return acc;
        endfunction

        function void push_result(logic kind, logic [BYTE_W-1:0] tx_byte, logic tx_last,
                                  logic [STAT_W-1:0] status, logic [WORD_W-1:0] value);
            link_result_t r;
            r.kind       = kind;
            r.tx_byte    = tx_byte;
            r.tx_last    = tx_last;
            r.status     = status;
            r.read_value = value;
            due_results.push_back(r);
        endfunction

        // Apply one accepted input transfer and queue the results it causes.
        function void take_item(link_item_t it);
            logic [BYTE_W-1:0] frame [8];
            logic [BYTE_W-1:0] crc;
            int unsigned       len;
            accepted_items++;
            case (it.cmd)
                CMD_WRITE, CMD_READ:
                begin
                    if (link_phase != PH_IDLE)
                        push_result(KIND_REPORT, '0, 1'b0, ST_REJECTED, '0);
                    else
                    begin
                        frame[0] = SYNC_BYTE;
                        frame[1] = it.slave_addr;
                        if (it.cmd == CMD_WRITE)
                        begin
                            frame[2] = {1'b0, it.reg_addr} | WRITE_BIT;
                            frame[3] = it.write_value[31:24];
                            frame[4] = it.write_value[23:16];
                            frame[5] = it.write_value[15:8];
                            frame[6] = it.write_value[7:0];
                            len      = 32'(WRITE_LEN);
                            enter_phase(PH_WECHO);
                        end
                        else
                        begin
                            frame[2] = {1'b0, it.reg_addr};
                            len      = 32'(READ_LEN);
                            enter_phase(PH_RECHO);
                        end
                        crc = '0;
                        for (int i = 0; i < len - 1; i++)
                        begin
                            crc = crc8_byte(crc, frame[i]);
                            push_result(KIND_TX, frame[i], 1'b0, ST_OK, '0);
                        end
                        push_result(KIND_TX, crc, 1'b1, ST_OK, '0);
                    end
                end
                CMD_RXB:
                begin
                    // Echo bytes are only counted; reply bytes feed CRC and value.
                    case (link_phase)
                        PH_WECHO:
                        begin
                            byte_cnt++;
                            if (byte_cnt >= WRITE_LEN)
                                enter_phase(PH_IDLE);
                        end
                        PH_RECHO:
                        begin
                            byte_cnt++;
                            if (byte_cnt >= READ_LEN)
                                enter_phase(PH_REPLY);
                        end
                        PH_REPLY:
                        begin
                            if (byte_cnt < REPLY_LEN)
                            begin
                                reply_crc = crc8_byte(reply_crc, it.rx_byte);
                                if (byte_cnt >= HDR_LEN)
                                    reply_word = {reply_word[WORD_W-BYTE_W-1:0], it.rx_byte};
                                byte_cnt++;
                            end
                            else
                            begin
                                if (it.rx_byte == reply_crc)
                                    push_result(KIND_REPORT, '0, 1'b0, ST_OK, reply_word);
                                else
                                    push_result(KIND_REPORT, '0, 1'b0, ST_CRC_ERR, '0);
                                enter_phase(PH_IDLE);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_TICK:
                begin
                    // The count saturates and is compared after the increment.
                    if (link_phase != PH_IDLE)
                    begin
                        if (tick_cnt != '1)
                            tick_cnt++;
                        case (link_phase)
                            PH_WECHO:
                                if (tick_cnt >= write_echo_limit)
                                    enter_phase(PH_IDLE);
                            PH_RECHO:
                                if (tick_cnt >= read_echo_limit)
                                    enter_phase(PH_REPLY);
                            default:
                                if (tick_cnt >= reply_limit)
                                begin
                                    push_result(KIND_REPORT, '0, 1'b0, ST_TIMEOUT, '0);
                                    enter_phase(PH_IDLE);
                                end
                        endcase
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
            if (want !== got)
            begin
                failures++;
                if (printed < 60)
                begin
                    printed++;
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
                end
            end
        endfunction

        // Compare one result transfer with the oldest predicted result.
        function void match_result(link_result_t got);
            link_result_t want;
            if (due_results.size() == 0)
            begin
                failures++;
                if (printed < 60)
                begin
                    printed++;
                    $display("%0t: result with none expected, actual kind %0d tx_byte %02h %s",
                             $time, got.kind, got.tx_byte,
                             $sformatf("tx_last %0d status %0d read_value %08h",
                                       got.tx_last, got.status, got.read_value));
                end
            end
            else
            begin
                want = due_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(got.kind));
                check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
                check_field("tx_last", 32'(want.tx_last), 32'(got.tx_last));
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("read_value", want.read_value, got.read_value);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFGI_W-1:0] cfg_index;
    logic [TICK_W-1:0] cfg_wdata;
    bit                calm = 1'b0;
    datagram_tracker   tracker;

    swrdm_in_if  in_ch ();
    swrdm_out_if out_ch ();

    single_wire_register_datagram_master_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always #5 clk = ~clk;

    // Sample both channels at the rising edge and update the model.
    always @(posedge clk)
    begin : port_watch
        link_item_t   item;
        link_result_t res;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                res.kind       = out_ch.kind;
                res.tx_byte    = out_ch.tx_byte;
                res.tx_last    = out_ch.tx_last;
                res.status     = out_ch.status;
                res.read_value = out_ch.read_value;
                tracker.match_result(res);
            end
            if (in_ch.valid && in_ch.ready)
            begin
                item.cmd         = in_ch.cmd;
                item.slave_addr  = in_ch.slave_addr;
                item.reg_addr    = in_ch.reg_addr;
                item.write_value = in_ch.write_value;
                item.rx_byte     = in_ch.rx_byte;
                tracker.take_item(item);
            end
        end
    end

    // Result sink: ready toggles in random bursts, held high in the calm tail.
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left     = 0;
        out_ch.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                out_ch.ready = 1'b1;
            else if (hold_left != 0)
                hold_left--;
            else if (out_ch.ready && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready = 1'b0;
                hold_left    = $urandom_range(0, 7);
            end
            else
            begin
                out_ch.ready = 1'b1;
                hold_left    = $urandom_range(0, 15);
            end
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("single_wire_register_datagram_master_unit regression: fail");
        $finish;
    end

    function automatic link_item_t make_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] addr,
                                             logic [REG_W-1:0] regad, logic [WORD_W-1:0] value,
                                             logic [BYTE_W-1:0] rx);
        link_item_t it;
        it.cmd         = cmd;
        it.slave_addr  = addr;
        it.reg_addr    = regad;
        it.write_value = value;
        it.rx_byte     = rx;
        return it;
    endfunction

    function automatic link_item_t random_item(logic [CMD_W-1:0] cmd);
        return make_item(cmd, BYTE_W'($urandom_range(0, 255)), REG_W'($urandom_range(0, 127)),
                         $urandom(), BYTE_W'($urandom_range(0, 255)));
    endfunction

    // Present one transfer at the falling edge, after an optional gap,
    // and return once it is accepted. Valid stays high for a following item.
    task automatic send_item(input link_item_t it);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.cmd         = it.cmd;
        in_ch.slave_addr  = it.slave_addr;
        in_ch.reg_addr    = it.reg_addr;
        in_ch.write_value = it.write_value;
        in_ch.rx_byte     = it.rx_byte;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and let every predicted result drain.
    task automatic settle_link();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_limits(input logic [TICK_W-1:0] write_echo,
                               input logic [TICK_W-1:0] read_echo,
                               input logic [TICK_W-1:0] reply);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = CFG_WRITE_ECHO;
        cfg_wdata = write_echo;
        tracker.write_echo_limit = write_echo;
        @(negedge clk);
        cfg_index = CFG_READ_ECHO;
        cfg_wdata = read_echo;
        tracker.read_echo_limit = read_echo;
        @(negedge clk);
        cfg_index = CFG_REPLY;
        cfg_wdata = reply;
        tracker.reply_limit = reply;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Occasional tick or stray request inside an otherwise clean exchange.
    task automatic sprinkle();
        if ($urandom_range(0, 5) == 0)
            send_item(random_item(CMD_TICK));
        else if ($urandom_range(0, 19) == 0)
            send_item(random_item(CMD_W'($urandom_range(0, 1))));
    endtask

    // Echo bytes, sometimes cut short and followed by ticks instead.
    task automatic run_echo(input int unsigned full_len);
        int unsigned n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, full_len - 1) : full_len;
        repeat (n)
        begin
            sprinkle();
            send_item(random_item(CMD_RXB));
        end
        if (n < full_len)
            repeat ($urandom_range(1, 24)) send_item(random_item(CMD_TICK));
    endtask

    // Seven reply bytes and a CRC byte that is usually right, or fewer and ticks.
    task automatic run_reply();
        logic [BYTE_W-1:0] crc;
        link_item_t        it;
        int unsigned       n;
        crc = '0;
        n   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 7;
        for (int i = 0; i < n; i++)
        begin
            sprinkle();
            it  = random_item(CMD_RXB);
            crc = tracker.crc8_byte(crc, it.rx_byte);
            send_item(it);
        end
        if (n < 7)
            repeat ($urandom_range(1, 24)) send_item(random_item(CMD_TICK));
        else
        begin
            it = random_item(CMD_RXB);
            if ($urandom_range(0, 4) != 0)
                it.rx_byte = crc;
            sprinkle();
            send_item(it);
        end
    endtask

    task automatic random_exchange();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            send_item(random_item(CMD_WRITE));
            run_echo(32'(WRITE_LEN));
        end
        else if (pick < 7)
        begin
            send_item(random_item(CMD_READ));
            run_echo(32'(READ_LEN));
            run_reply();
        end
        else if (pick < 9)
        begin
            send_item(random_item(pick == 7 ? CMD_READ : CMD_WRITE));
            repeat ($urandom_range(1, 30)) send_item(random_item(CMD_TICK));
        end
        else
            repeat ($urandom_range(1, 4)) send_item(random_item(CMD_W'($urandom_range(0, 3))));
    endtask

    // Random exchanges until enough transfers have been accepted.
    task automatic run_phase(input int unsigned quota);
        int unsigned start;
        start = tracker.accepted_items;
        while (tracker.accepted_items - start < quota)
            random_exchange();
    endtask

    // Main sequence
    initial
    begin : main_flow
        logic [BYTE_W-1:0] answer [7];
        logic [BYTE_W-1:0] crc;
        tracker           = new();
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_WRITE_ECHO;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_TICK;
        in_ch.slave_addr  = '0;
        in_ch.reg_addr    = '0;
        in_ch.write_value = '0;
        in_ch.rx_byte     = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored tick and byte, full write with a rejected request,
        // then a full read with a good reply, all at the reset tick limits.
        send_item(make_item(CMD_TICK, '0, '0, '0, '0));
        send_item(make_item(CMD_RXB, '1, '1, '1, '1));
        send_item(make_item(CMD_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'h00));
        send_item(make_item(CMD_READ, '0, '0, '0, '0));
        for (int i = 0; i < 8; i++)
            send_item(make_item(CMD_RXB, '0, '0, '0, i[0] ? 8'hFF : 8'h00));
        send_item(make_item(CMD_READ, 8'h5A, 7'h25, 32'h1234_5678, 8'h00));
        for (int i = 0; i < 4; i++)
            send_item(make_item(CMD_RXB, '0, '0, '0, 8'hC3));
        answer = '{8'h05, 8'hFF, 8'h7F, 8'h00, 8'hFF, 8'hA5, 8'h3C};
        crc    = '0;
        for (int i = 0; i < 7; i++)
        begin
            crc = tracker.crc8_byte(crc, answer[i]);
            send_item(make_item(CMD_RXB, '0, '0, '0, answer[i]));
        end
        send_item(make_item(CMD_RXB, '0, '0, '0, crc));

        // Random phases over several tick limit settings
        run_phase(40);
        settle_link();
        load_limits(8'd1, 8'd1, 8'd1);
        run_phase(35);
        settle_link();
        load_limits('1, '1, '1);
        run_phase(35);
        settle_link();
        load_limits(TICK_W'($urandom_range(1, 40)), TICK_W'($urandom_range(1, 40)),
                    TICK_W'($urandom_range(1, 40)));
        run_phase(35);
        settle_link();
        load_limits(8'd2, 8'd7, 8'd12);
        calm = 1'b1;
        run_phase(15);

        settle_link();
        repeat (20) @(posedge clk);
        if (tracker.failures == 0 && tracker.due_results.size() == 0)
            $display("single_wire_register_datagram_master_unit regression: pass");
        else
            $display("single_wire_register_datagram_master_unit regression: fail");
        $finish;
    end

endmodule
